@@ rtl/pspi_pkg.sv @@
// pspi_pkg: shared widths, codes and types for the partial shuffle index picker
// no dependencies

package pspi_pkg;

  localparam int CountW  = 13;  // counts and configuration values
  localparam int PickW   = 12;  // picked index on the result word
  localparam int WordW   = 32;  // random word of a draw
  localparam int EpochW  = 8;   // selection tag stored beside each slot
  localparam int CfgIdxW = 1;   // configuration register index

  typedef logic [CountW-1:0]  count_t;
  typedef logic [PickW-1:0]   pick_t;
  typedef logic [WordW-1:0]   word_t;
  typedef logic [EpochW-1:0]  epoch_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t RegTableSize   = 1'b0;
  localparam cfg_idx_t RegSelectCount = 1'b1;

  // action codes
  localparam logic ActStart = 1'b0;
  localparam logic ActDraw  = 1'b1;

  // epoch value written by the clearing pass; never a live epoch
  localparam epoch_t EpochStale = '0;
  localparam epoch_t EpochFirst = epoch_t'(1);
  localparam epoch_t EpochLast  = '1;

endpackage

@@ rtl/pspi_slot_ram.sv @@
// pspi_slot_ram: true dual-port synchronous slot memory, registered read
// depends on nothing; instantiated by partial_shuffle_index_picker

module pspi_slot_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 20
) (
  input  logic                     clk_i,
  input  logic                     a_en_i,
  input  logic                     a_we_i,
  input  logic [$clog2(DEPTH)-1:0] a_addr_i,
  input  logic [WIDTH-1:0]         a_wdata_i,
  output logic [WIDTH-1:0]         a_rdata_o,
  input  logic                     b_en_i,
  input  logic                     b_we_i,
  input  logic [$clog2(DEPTH)-1:0] b_addr_i,
  input  logic [WIDTH-1:0]         b_wdata_i,
  output logic [WIDTH-1:0]         b_rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (a_en_i) begin
      if (a_we_i) begin
        mem[a_addr_i] <= a_wdata_i;
      end else begin
        a_rdata_o <= mem[a_addr_i];
      end
    end
    if (b_en_i) begin
      if (b_we_i) begin
        mem[b_addr_i] <= b_wdata_i;
      end else begin
        b_rdata_o <= mem[b_addr_i];
      end
    end
  end

endmodule

@@ rtl/partial_shuffle_index_picker.sv @@
// partial_shuffle_index_picker: draws distinct indices by a partial shuffle over a slot ram
// depends on pspi_pkg and pspi_slot_ram

// usage
// - command port: a word is taken at a clock edge where start is high and busy is low.
//   action_i selects start of a new selection or one draw; random_word_i feeds a draw
// - a start gives no result; a draw gives exactly one result word, shown for one cycle
//   with result_valid_o high; the receiver cannot stall, so the word must be taken then
// - an ordinary draw: after acceptance it runs the multiply, the slot read and the swap
//   write-back on the dual-port slot ram with busy high; the result word is registered
//   out of the write-back, and no new draw is taken until the last one is through
// - a draw past the selected count: overrun result the next cycle, no busy time
// - a start: busy stays low, the next word can follow in the next cycle, except every
//   255th start, which runs a clearing pass over all TABLE_DEPTH slots with busy high
// - reset: control state clears and a clearing pass over all TABLE_DEPTH slots runs with
//   busy high before the first word is taken; configuration writes are taken at all times
// - configuration: cfg_we_i with cfg_index_i (0 table size, 1 select count), no read-back
// - each slot carries an epoch tag; a slot whose tag is not the current epoch reads as
//   its own index, so a start only has to advance the epoch

module partial_shuffle_index_picker #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  pspi_pkg::cfg_idx_t cfg_index_i,
  input  pspi_pkg::count_t   cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic               action_i,
  input  pspi_pkg::word_t    random_word_i,
  output logic               result_valid_o,
  output pspi_pkg::pick_t    picked_index_o,
  output logic               last_o,
  output logic               overrun_o
);

  import pspi_pkg::*;

  localparam int AddrW  = $clog2(TABLE_DEPTH);
  localparam int EntryW = EpochW + AddrW;
  localparam int ProdW  = WordW + CountW;
  localparam logic [31:0] DepthW = 32'(TABLE_DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_READ,
    ST_WRITE
  } state_e;

  state_e state_q, state_d;

  // configuration
  count_t table_size_q, select_count_q;

  // selection state
  count_t draws_done_q, draws_done_d;
  epoch_t epoch_q, epoch_d;
  logic [AddrW-1:0] clr_q, clr_d;

  // draw in flight
  word_t  word_q;
  count_t k_q, rem_q, chosen_q;
  logic   last_pend_q;

  // result word
  logic   res_valid_q, res_valid_d;
  pick_t  res_pick_q, res_pick_d;
  logic   res_last_q, res_last_d;
  logic   res_ovr_q, res_ovr_d;

  // ram ports
  logic              a_en, a_we, b_en, b_we;
  logic [AddrW-1:0]  a_addr, b_addr;
  logic [EntryW-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

  // effective size and select count
  count_t eff_size, eff_sel;
  logic   accept, overrun_now;
  logic [ProdW-1:0] prod;
  count_t chosen_d;
  logic [AddrW-1:0] at_k, at_c;

  assign eff_size    = (32'(table_size_q) > DepthW) ? CountW'(TABLE_DEPTH) : table_size_q;
  assign eff_sel     = (select_count_q > eff_size) ? eff_size : select_count_q;
  assign accept      = start && !busy;
  assign overrun_now = (draws_done_q >= eff_sel);

  // offset into the remaining range is the high part of word times remaining
  assign prod     = ProdW'(word_q) * ProdW'(rem_q);
  assign chosen_d = k_q + prod[ProdW-1:WordW];

  // slots with a stale tag read as their own index
  assign at_k = (a_rdata[EntryW-1 -: EpochW] == epoch_q) ? a_rdata[AddrW-1:0]
                                                         : AddrW'(k_q);
  assign at_c = (b_rdata[EntryW-1 -: EpochW] == epoch_q) ? b_rdata[AddrW-1:0]
                                                         : AddrW'(chosen_q);

  always_comb begin
    state_d      = state_q;
    draws_done_d = draws_done_q;
    epoch_d      = epoch_q;
    clr_d        = clr_q;
    res_valid_d  = 1'b0;
    res_pick_d   = '0;
    res_last_d   = 1'b0;
    res_ovr_d    = 1'b0;
    a_en = 1'b0; a_we = 1'b0; a_addr = '0; a_wdata = '0;
    b_en = 1'b0; b_we = 1'b0; b_addr = '0; b_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        a_en    = 1'b1;
        a_we    = 1'b1;
        a_addr  = clr_q;
        a_wdata = {EpochStale, {AddrW{1'b0}}};
        clr_d   = clr_q + 1'b1;
        if (clr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ActStart) begin
            draws_done_d = '0;
            if (epoch_q == EpochLast) begin
              // tags about to repeat: wipe them all
              epoch_d = EpochFirst;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + 1'b1;
            end
          end else if (overrun_now) begin
            res_valid_d = 1'b1;
            res_ovr_d   = 1'b1;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_READ;
      end
      ST_READ: begin
        a_en   = 1'b1;
        a_addr = AddrW'(k_q);
        b_en   = 1'b1;
        b_addr = AddrW'(chosen_q);
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        // swap: slot chosen gets slot k, slot k gets slot chosen
        a_en    = 1'b1;
        a_we    = 1'b1;
        a_addr  = AddrW'(chosen_q);
        a_wdata = {epoch_q, at_k};
        b_en    = (chosen_q != k_q);
        b_we    = 1'b1;
        b_addr  = AddrW'(k_q);
        b_wdata = {epoch_q, at_c};
        draws_done_d = k_q + 1'b1;
        res_valid_d  = 1'b1;
        res_pick_d   = PickW'(at_c);
        res_last_d   = last_pend_q;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      epoch_q        <= EpochFirst;
      draws_done_q   <= '0;
      table_size_q   <= CountW'(4096);
      select_count_q <= '0;
      res_valid_q    <= 1'b0;
      res_pick_q     <= '0;
      res_last_q     <= 1'b0;
      res_ovr_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      epoch_q      <= epoch_d;
      draws_done_q <= draws_done_d;
      res_valid_q  <= res_valid_d;
      res_pick_q   <= res_pick_d;
      res_last_q   <= res_last_d;
      res_ovr_q    <= res_ovr_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegTableSize:   table_size_q   <= cfg_data_i;
          RegSelectCount: select_count_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // draw operands; no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      word_q      <= random_word_i;
      k_q         <= draws_done_q;
      rem_q       <= eff_size - draws_done_q;
      last_pend_q <= ((draws_done_q + 1'b1) == eff_sel);
    end
    if (state_q == ST_MUL) begin
      chosen_q <= chosen_d;
    end
  end

  pspi_slot_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EntryW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .a_en_i    (a_en),
    .a_we_i    (a_we),
    .a_addr_i  (a_addr),
    .a_wdata_i (a_wdata),
    .a_rdata_o (a_rdata),
    .b_en_i    (b_en),
    .b_we_i    (b_we),
    .b_addr_i  (b_addr),
    .b_wdata_i (b_wdata),
    .b_rdata_o (b_rdata)
  );

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign picked_index_o = res_pick_q;
  assign last_o         = res_last_q;
  assign overrun_o      = res_ovr_q;

  // the stale tag must never be the live epoch
  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != EpochStale)
    else $error("epoch reached the stale tag");

  // the swap write-back always delivers one non-overrun word
  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |=> result_valid_o && !overrun_o)
    else $error("draw finished without a result word");

  // the chosen slot lies in the remaining range
  a_chosen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> (chosen_q >= k_q) && ((chosen_q - k_q) < rem_q))
    else $error("chosen slot out of range");

  // a clearing pass blocks the command port
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> busy && !result_valid_o)
    else $error("command port open during clearing pass");

endmodule
